FILE: src/fdc_regs_pkg.sv
// ----------------------------------------------------------------------------
// fdc_regs_pkg
// Shared types, codes and constants for the floppy controller register block.
// ----------------------------------------------------------------------------
package fdc_regs_pkg;

   // Number of drives on the select lines of latch A
   localparam int DRIVE_COUNT = 4;
   localparam int SEL_LIMIT   = (DRIVE_COUNT < 4) ? DRIVE_COUNT : 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_VARIANT      = 2'd0;
   localparam logic [1:0] CSR_DRIVE_BYPASS = 2'd1;
   localparam logic [1:0] CSR_CHANGE_CLEAR = 2'd2;

   // Transaction kinds
   localparam logic [3:0] CMD_REG_WRITE = 4'd0;
   localparam logic [3:0] CMD_REG_READ  = 4'd1;
   localparam logic [3:0] CMD_LATCH_A   = 4'd2;
   localparam logic [3:0] CMD_LATCH_B   = 4'd3;
   localparam logic [3:0] CMD_BYTE      = 4'd4;
   localparam logic [3:0] CMD_GETDATA   = 4'd5;
   localparam logic [3:0] CMD_DONE      = 4'd6;
   localparam logic [3:0] CMD_NOTFOUND  = 4'd7;
   localparam logic [3:0] CMD_DATACRC   = 4'd8;
   localparam logic [3:0] CMD_HDRCRC    = 4'd9;
   localparam logic [3:0] CMD_WPROT     = 4'd10;
   localparam logic [3:0] CMD_INDEX     = 4'd11;
   localparam logic [3:0] CMD_SPINDOWN  = 4'd12;

   // Register addresses
   localparam logic [1:0] REG_CMD_STATUS = 2'd0;
   localparam logic [1:0] REG_TRACK      = 2'd1;
   localparam logic [1:0] REG_SECTOR     = 2'd2;
   localparam logic [1:0] REG_DATA       = 2'd3;

   // Controller opcodes (upper nibble of the command byte)
   localparam logic [3:0] OPC_RESTORE     = 4'h0;
   localparam logic [3:0] OPC_SEEK        = 4'h1;
   localparam logic [3:0] OPC_STEP        = 4'h2;
   localparam logic [3:0] OPC_STEP_U      = 4'h3;
   localparam logic [3:0] OPC_STEP_IN     = 4'h4;
   localparam logic [3:0] OPC_STEP_IN_U   = 4'h5;
   localparam logic [3:0] OPC_STEP_OUT    = 4'h6;
   localparam logic [3:0] OPC_STEP_OUT_U  = 4'h7;
   localparam logic [3:0] OPC_READ_SECTOR = 4'h8;
   localparam logic [3:0] OPC_WRITE_SECT  = 4'hA;
   localparam logic [3:0] OPC_READ_ADDR   = 4'hC;
   localparam logic [3:0] OPC_FORCE_INT   = 4'hD;
   localparam logic [3:0] OPC_FORMAT      = 4'hF;

   // Interrupt and data-request actions
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_RAISE = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Drive requests
   localparam logic [2:0] OP_NONE         = 3'd0;
   localparam logic [2:0] OP_SEEK         = 3'd1;
   localparam logic [2:0] OP_READ_SECTOR  = 3'd2;
   localparam logic [2:0] OP_WRITE_SECTOR = 3'd3;
   localparam logic [2:0] OP_READ_ADDR    = 3'd4;
   localparam logic [2:0] OP_FORMAT       = 3'd5;
   localparam logic [2:0] OP_STOP_ALL     = 3'd6;
   localparam logic [2:0] OP_STOP_CURRENT = 3'd7;

   // Step directions
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_IN   = 2'd1;
   localparam logic [1:0] DIR_OUT  = 2'd2;

   // Status values
   localparam logic [7:0] ST_TYPE1      = 8'h21;
   localparam logic [7:0] ST_MOTOR      = 8'h80;
   localparam logic [7:0] ST_RD_BUSY    = 8'h81;
   localparam logic [7:0] ST_WR_BUSY    = 8'h83;
   localparam logic [7:0] ST_OVERRUN    = 8'h84;
   localparam logic [7:0] ST_TRK0       = 8'h04;
   localparam logic [7:0] ST_BUSY       = 8'h01;
   localparam logic [7:0] ST_DRQ        = 8'h02;
   localparam logic [7:0] ST_RNF_ERR    = 8'h10;
   localparam logic [7:0] ST_CRC_ERR    = 8'h08;
   localparam logic [7:0] ST_HDRCRC_ERR = 8'h18;
   localparam logic [7:0] ST_WPROT_ERR  = 8'h40;

   localparam logic [2:0] INDEX_MAX     = 3'd7;
   localparam logic [2:0] INDEX_RNF     = 3'd5;

   typedef struct packed {
      logic       variant;
      logic       drive_bypass;
      logic       change_clear_enable;
   } cfg_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic [1:0] reg_addr;
      logic [7:0] value;
      logic       last_byte;
      logic       disc_present;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       data_valid;
      logic [1:0] irq_action;
      logic [1:0] drq_action;
      logic [2:0] drive_op;
      logic [7:0] drive_track;
      logic [7:0] drive_sector;
      logic       drive_side;
      logic       drive_density;
      logic [1:0] drive_select;
      logic       motor_on;
      logic       change_clear;
   } rsp_type;

endpackage

FILE: src/fdc_regs_exec.sv
// ----------------------------------------------------------------------------
// fdc_regs_exec
// Controller register file and the decode of one transaction: next state and
// result are worked out in one pass, state is updated when step is high.
// ----------------------------------------------------------------------------
module fdc_regs_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  fdc_regs_pkg::cfg_type cfg,
   input  fdc_regs_pkg::req_type req,
   output fdc_regs_pkg::rsp_type rsp
);
   import fdc_regs_pkg::*;

   logic [7:0] command_ff, command_in;
   logic [7:0] track_ff, track_in;
   logic [7:0] sector_ff, sector_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] head_ff, head_in;
   logic [1:0] dir_ff, dir_in;
   logic       side_ff, side_in;
   logic       dens_ff, dens_in;
   logic       written_ff, written_in;
   logic [2:0] index_ff, index_in;
   logic       rnf_ff, rnf_in;
   logic [1:0] select_ff, select_in;
   logic       motor_ff, motor_in;
   logic       nrdy_ff, nrdy_in;

   logic [3:0] opc;
   logic [3:0] done_opc;
   logic [7:0] trk0;
   logic [7:0] head_up;
   logic [7:0] head_down;

   assign opc       = req.value[7:4];
   assign done_opc  = command_ff[7:4];
   assign trk0      = (head_ff == 8'd0) ? ST_TRK0 : 8'd0;
   assign head_up   = (head_ff != 8'hFF) ? head_ff + 8'd1 : head_ff;
   assign head_down = (head_ff != 8'd0) ? head_ff - 8'd1 : head_ff;

   // Transaction decode
   always_comb begin
      command_in = command_ff;
      track_in   = track_ff;
      sector_in  = sector_ff;
      status_in  = status_ff;
      data_in    = data_ff;
      head_in    = head_ff;
      dir_in     = dir_ff;
      side_in    = side_ff;
      dens_in    = dens_ff;
      written_in = written_ff;
      index_in   = index_ff;
      rnf_in     = rnf_ff;
      select_in  = select_ff;
      motor_in   = motor_ff;
      nrdy_in    = nrdy_ff;
      rsp        = '0;

      unique case (req.cmd)
         CMD_REG_WRITE: begin
            unique case (req.reg_addr)
               REG_CMD_STATUS: begin
                  // busy rejects all but force interrupt
                  if (!(status_ff[0] && opc != OPC_FORCE_INT)) begin
                     command_in = req.value;
                     unique case (opc)
                        OPC_RESTORE: begin
                           status_in = ST_MOTOR | ST_TYPE1 | trk0;
                           if (!cfg.drive_bypass) rsp.drive_op = OP_SEEK;
                        end
                        OPC_SEEK: begin
                           status_in = ST_MOTOR | ST_TYPE1 | trk0;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_SEEK;
                              rsp.drive_track = data_ff;
                           end
                        end
                        OPC_STEP, OPC_STEP_U: begin
                           status_in = ST_MOTOR | ST_TYPE1 | trk0;
                           if (dir_ff == DIR_IN) head_in = head_up;
                           else if (dir_ff == DIR_OUT) head_in = head_down;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_SEEK;
                              rsp.drive_track = head_in;
                           end
                        end
                        OPC_STEP_IN, OPC_STEP_IN_U: begin
                           status_in = ST_MOTOR | ST_TYPE1 | trk0;
                           head_in   = head_up;
                           dir_in    = DIR_IN;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_SEEK;
                              rsp.drive_track = head_up;
                           end
                        end
                        OPC_STEP_OUT, OPC_STEP_OUT_U: begin
                           status_in = ST_MOTOR | ST_TYPE1 | trk0;
                           head_in   = head_down;
                           dir_in    = DIR_OUT;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_SEEK;
                              rsp.drive_track = head_down;
                           end
                        end
                        OPC_READ_SECTOR: begin
                           status_in = ST_RD_BUSY;
                           index_in  = 3'd0;
                           rnf_in    = 1'b1;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op     = OP_READ_SECTOR;
                              rsp.drive_track  = track_ff;
                              rsp.drive_sector = sector_ff;
                           end
                        end
                        OPC_WRITE_SECT: begin
                           status_in      = ST_WR_BUSY;
                           rsp.drq_action = ACT_RAISE;
                           written_in     = 1'b0;
                           index_in       = 3'd0;
                           rnf_in         = 1'b1;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op     = OP_WRITE_SECTOR;
                              rsp.drive_track  = track_ff;
                              rsp.drive_sector = sector_ff;
                           end
                        end
                        OPC_READ_ADDR: begin
                           status_in = ST_RD_BUSY;
                           index_in  = 3'd0;
                           rnf_in    = 1'b1;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_READ_ADDR;
                              rsp.drive_track = track_ff;
                           end
                        end
                        OPC_FORCE_INT: begin
                           status_in = ST_MOTOR | trk0;
                           if (req.value[3]) rsp.irq_action = ACT_RAISE;
                           if (!cfg.drive_bypass) rsp.drive_op = OP_STOP_ALL;
                        end
                        OPC_FORMAT: begin
                           status_in = ST_RD_BUSY;
                           if (!cfg.drive_bypass) begin
                              rsp.drive_op    = OP_FORMAT;
                              rsp.drive_track = track_ff;
                           end
                        end
                        default: begin
                           // undefined opcodes end in an error
                           status_in      = ST_RNF_ERR;
                           rsp.irq_action = ACT_RAISE;
                        end
                     endcase
                  end
               end
               REG_TRACK:  track_in  = req.value;
               REG_SECTOR: sector_in = req.value;
               REG_DATA: begin
                  rsp.drq_action = ACT_CLEAR;
                  status_in      = status_ff & ~ST_DRQ;
                  data_in        = req.value;
                  written_in     = 1'b1;
               end
            endcase
         end

         CMD_REG_READ: begin
            unique case (req.reg_addr)
               REG_CMD_STATUS: begin
                  rsp.irq_action = ACT_CLEAR;
                  rsp.read_data  = cfg.variant ? {nrdy_ff, status_ff[6:0]} : status_ff;
               end
               REG_TRACK:  rsp.read_data = track_ff;
               REG_SECTOR: rsp.read_data = sector_ff;
               REG_DATA: begin
                  rsp.drq_action = ACT_CLEAR;
                  status_in      = status_ff & ~ST_DRQ;
                  rsp.read_data  = data_ff;
               end
            endcase
         end

         CMD_LATCH_A: begin
            // highest numbered cleared select bit wins
            if (!cfg.drive_bypass) begin
               for (int d = 0; d < SEL_LIMIT; d++) begin
                  if (!req.value[d]) select_in = 2'(d);
               end
               motor_in = !req.value[5];
            end
            side_in = !req.value[4];
            nrdy_in = !(motor_in && req.disc_present && !cfg.drive_bypass);
            rsp.change_clear = !req.value[7] && req.disc_present && cfg.change_clear_enable;
         end

         CMD_LATCH_B: begin
            dens_in = cfg.variant ? req.value[2] : !req.value[1];
         end

         CMD_BYTE: begin
            if (status_ff[1]) begin
               // overrun: stop the drive even in bypass
               status_in      = ST_OVERRUN;
               rsp.irq_action = ACT_RAISE;
               rsp.drive_op   = OP_STOP_CURRENT;
            end else begin
               data_in        = req.value;
               status_in      = status_ff | ST_DRQ;
               rsp.drq_action = ACT_RAISE;
            end
         end

         CMD_GETDATA: begin
            if (written_ff) begin
               if (!req.last_byte) begin
                  rsp.drq_action = ACT_RAISE;
                  status_in      = status_ff | ST_DRQ;
               end
               written_in     = 1'b0;
               rsp.read_data  = data_ff;
               rsp.data_valid = 1'b1;
            end
         end

         CMD_DONE: begin
            rnf_in = 1'b0;
            unique case (done_opc)
               OPC_RESTORE: begin
                  head_in        = 8'd0;
                  track_in       = 8'd0;
                  status_in      = ST_OVERRUN;
                  rsp.irq_action = ACT_RAISE;
               end
               OPC_SEEK: begin
                  head_in        = data_ff;
                  track_in       = data_ff;
                  status_in      = ST_MOTOR | ((data_ff == 8'd0) ? ST_TRK0 : 8'd0);
                  rsp.irq_action = ACT_RAISE;
               end
               OPC_STEP_U, OPC_STEP_IN_U, OPC_STEP_OUT_U: begin
                  track_in       = head_ff;
                  status_in      = ST_MOTOR | trk0;
                  rsp.irq_action = ACT_RAISE;
               end
               OPC_STEP, OPC_STEP_IN, OPC_STEP_OUT: begin
                  status_in      = ST_MOTOR | trk0;
                  rsp.irq_action = ACT_RAISE;
               end
               OPC_READ_SECTOR: begin
                  status_in      = ST_MOTOR | (status_ff & ST_TRK0);
                  rsp.irq_action = ACT_RAISE;
               end
               OPC_READ_ADDR: begin
                  status_in      = ST_MOTOR | (status_ff & ST_TRK0);
                  rsp.irq_action = ACT_RAISE;
                  sector_in      = track_ff;
               end
               OPC_WRITE_SECT, OPC_FORMAT: begin
                  status_in      = ST_MOTOR;
                  rsp.irq_action = ACT_RAISE;
               end
               default: begin
                  // force interrupt and undefined opcodes only disarm
               end
            endcase
         end

         CMD_NOTFOUND: begin
            status_in      = ST_RNF_ERR;
            rsp.irq_action = ACT_RAISE;
         end
         CMD_DATACRC: begin
            status_in      = ST_CRC_ERR;
            rsp.irq_action = ACT_RAISE;
         end
         CMD_HDRCRC: begin
            status_in      = ST_HDRCRC_ERR;
            rsp.irq_action = ACT_RAISE;
         end
         CMD_WPROT: begin
            status_in      = ST_WPROT_ERR;
            rsp.irq_action = ACT_RAISE;
         end

         CMD_INDEX: begin
            if (index_ff != INDEX_MAX) index_in = index_ff + 3'd1;
            if (index_in == INDEX_RNF && rnf_ff) begin
               status_in      = ST_RNF_ERR;
               rsp.irq_action = ACT_RAISE;
            end
         end

         CMD_SPINDOWN: begin
            status_in = status_ff & ~ST_MOTOR;
         end

         default: begin
            // unused transaction kinds
         end
      endcase

      rsp.drive_side    = side_in;
      rsp.drive_density = dens_in;
      rsp.drive_select  = select_in;
      rsp.motor_on      = motor_in;
   end

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         track_ff   <= '0;
         sector_ff  <= '0;
         status_ff  <= '0;
         data_ff    <= '0;
         head_ff    <= '0;
         dir_ff     <= DIR_NONE;
         side_ff    <= 1'b0;
         dens_ff    <= 1'b0;
         written_ff <= 1'b0;
         index_ff   <= '0;
         rnf_ff     <= 1'b0;
         select_ff  <= '0;
         motor_ff   <= 1'b0;
         nrdy_ff    <= 1'b0;
      end else if (step) begin
         command_ff <= command_in;
         track_ff   <= track_in;
         sector_ff  <= sector_in;
         status_ff  <= status_in;
         data_ff    <= data_in;
         head_ff    <= head_in;
         dir_ff     <= dir_in;
         side_ff    <= side_in;
         dens_ff    <= dens_in;
         written_ff <= written_in;
         index_ff   <= index_in;
         rnf_ff     <= rnf_in;
         select_ff  <= select_in;
         motor_ff   <= motor_in;
         nrdy_ff    <= nrdy_in;
      end
   end

endmodule

FILE: src/floppy_controller_registers_top.sv
// ----------------------------------------------------------------------------
// floppy_controller_registers_top
// Floppy controller command/status front end with request and response
// channels and a small configuration write port.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock and each gives exactly one response,
// in order. A transaction passes an input register, is decoded combinationally
// against the controller registers and lands in the response register, which
// offers it. Throughput is one per cycle while the response side keeps taking;
// req_ready drops only when both the input and the response register hold a
// transaction and the response is not being taken. Configuration writes take
// effect at once and belong to idle periods.
module floppy_controller_registers_top (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_cmd,
   input  logic [1:0] req_reg_addr,
   input  logic [7:0] req_value,
   input  logic       req_last_byte,
   input  logic       req_disc_present,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_data_valid,
   output logic [1:0] rsp_irq_action,
   output logic [1:0] rsp_drq_action,
   output logic [2:0] rsp_drive_op,
   output logic [7:0] rsp_drive_track,
   output logic [7:0] rsp_drive_sector,
   output logic       rsp_drive_side,
   output logic       rsp_drive_density,
   output logic [1:0] rsp_drive_select,
   output logic       rsp_motor_on,
   output logic       rsp_change_clear,

   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata
);
   import fdc_regs_pkg::*;

   cfg_type    cfg_ff;
   req_type    in_ff;
   logic       in_valid_ff, in_valid_in;
   rsp_type    rsp_ff, rsp_next;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   logic       advance;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VARIANT:      cfg_ff.variant             <= csr_wdata[0];
            CSR_DRIVE_BYPASS: cfg_ff.drive_bypass        <= csr_wdata[0];
            CSR_CHANGE_CLEAR: cfg_ff.change_clear_enable <= csr_wdata[0];
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_ff <= '{cmd: req_cmd, reg_addr: req_reg_addr, value: req_value,
                    last_byte: req_last_byte, disc_present: req_disc_present};
      end
   end

   fdc_regs_exec u_exec (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cfg   (cfg_ff),
      .req   (in_ff),
      .rsp   (rsp_next)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_data_valid    = rsp_ff.data_valid;
   assign rsp_irq_action    = rsp_ff.irq_action;
   assign rsp_drq_action    = rsp_ff.drq_action;
   assign rsp_drive_op      = rsp_ff.drive_op;
   assign rsp_drive_track   = rsp_ff.drive_track;
   assign rsp_drive_sector  = rsp_ff.drive_sector;
   assign rsp_drive_side    = rsp_ff.drive_side;
   assign rsp_drive_density = rsp_ff.drive_density;
   assign rsp_drive_select  = rsp_ff.drive_select;
   assign rsp_motor_on      = rsp_ff.motor_on;
   assign rsp_change_clear  = rsp_ff.change_clear;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - floppy controller register block testbench
// Sends bus accesses, latch writes and drive events through the request
// channel in random bursts while the response side stalls on a pattern of its
// own. A transaction-level predictor of the controller registers, status, head
// position and latch state works out each response, which is compared field
// by field in order. Six settings of the three control registers are run,
// each written while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import fdc_regs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 235;
   localparam int PHASE_COUNT     = 6;
   // {variant, drive_bypass, change_clear_enable} per phase, phase 0 lowest
   localparam logic [17:0] PHASE_SETTINGS =
      {3'b110, 3'b001, 3'b010, 3'b111, 3'b000, 3'b101};

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [3:0] req_cmd = CMD_REG_READ;
   logic [1:0] req_reg_addr = REG_CMD_STATUS;
   logic [7:0] req_value = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       req_disc_present = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_data_valid;
   logic [1:0] rsp_irq_action;
   logic [1:0] rsp_drq_action;
   logic [2:0] rsp_drive_op;
   logic [7:0] rsp_drive_track;
   logic [7:0] rsp_drive_sector;
   logic       rsp_drive_side;
   logic       rsp_drive_density;
   logic [1:0] rsp_drive_select;
   logic       rsp_motor_on;
   logic       rsp_change_clear;

   logic       csr_we = 1'b0;
   logic [1:0] csr_index = CSR_VARIANT;
   logic [0:0] csr_wdata = 1'b0;

   // Stimulus and expectation stores
   req_type    bus_events [$];
   rsp_type    predicted_outcomes [$];
   int         stim_count     = 0;
   int         mismatch_count = 0;
   int         rsp_count      = 0;
   int         cycle_count    = 0;

   // Sender burst / gap bookkeeping, receiver stall pattern
   int         burst_left = 1;
   int         gap_left   = 0;
   int         stall_mode = 0;
   int         stall_tick = 0;

   // Predicted controller state and settings
   cfg_type    fdc_cfg       = '0;
   logic [7:0] p_command     = 8'h00;
   logic [7:0] p_track       = 8'h00;
   logic [7:0] p_sector      = 8'h00;
   logic [7:0] p_status      = 8'h00;
   logic [7:0] p_data        = 8'h00;
   logic [7:0] p_head        = 8'h00;
   logic [1:0] p_step_dir    = DIR_NONE;
   logic       p_side        = 1'b0;
   logic       p_density     = 1'b0;
   logic       p_byte_ready  = 1'b0;
   logic [2:0] p_index_count = 3'd0;
   logic       p_rnf_watch   = 1'b0;
   logic [1:0] p_drive       = 2'd0;
   logic       p_motor       = 1'b0;
   logic       p_not_ready   = 1'b0;

   floppy_controller_registers_top i_dut (.*);

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive request, suppressed entirely when bypassing the drive
   function automatic void request_drive(inout rsp_type r, input logic [2:0] op,
                                         input logic [7:0] trk, input logic [7:0] sec);
      if (!fdc_cfg.drive_bypass) begin
         r.drive_op     = op;
         r.drive_track  = trk;
         r.drive_sector = sec;
      end
   endfunction

   function automatic void end_in_error(inout rsp_type r, input logic [7:0] code);
      r.irq_action = ACT_RAISE;
      p_status     = code;
   endfunction

   // Predicted response for one accepted transaction; updates the state copy
   function automatic rsp_type next_outcome(input req_type t);
      rsp_type    r;
      logic [3:0] opc;
      logic [7:0] trk0;
      r    = '0;
      opc  = t.value[7:4];
      trk0 = (p_head == 8'h00) ? ST_TRK0 : 8'h00;
      case (t.cmd)
         CMD_REG_WRITE: begin
            case (t.reg_addr)
               REG_CMD_STATUS: begin
                  // a busy controller only listens to force interrupt
                  if (!p_status[0] || opc == OPC_FORCE_INT) begin
                     p_command = t.value;
                     case (opc)
                        OPC_RESTORE: begin
                           p_status = ST_MOTOR | ST_TYPE1 | trk0;
                           request_drive(r, OP_SEEK, 8'h00, 8'h00);
                        end
                        OPC_SEEK: begin
                           p_status = ST_MOTOR | ST_TYPE1 | trk0;
                           request_drive(r, OP_SEEK, p_data, 8'h00);
                        end
                        OPC_STEP, OPC_STEP_U: begin
                           // no direction yet: head stays, seek still asked for
                           p_status = ST_MOTOR | ST_TYPE1 | trk0;
                           if (p_step_dir == DIR_IN && p_head != 8'hFF)
                              p_head = p_head + 8'd1;
                           else if (p_step_dir == DIR_OUT && p_head != 8'h00)
                              p_head = p_head - 8'd1;
                           request_drive(r, OP_SEEK, p_head, 8'h00);
                        end
                        OPC_STEP_IN, OPC_STEP_IN_U: begin
                           p_status = ST_MOTOR | ST_TYPE1 | trk0;
                           if (p_head != 8'hFF) p_head = p_head + 8'd1;
                           request_drive(r, OP_SEEK, p_head, 8'h00);
                           p_step_dir = DIR_IN;
                        end
                        OPC_STEP_OUT, OPC_STEP_OUT_U: begin
                           p_status = ST_MOTOR | ST_TYPE1 | trk0;
                           if (p_head != 8'h00) p_head = p_head - 8'd1;
                           request_drive(r, OP_SEEK, p_head, 8'h00);
                           p_step_dir = DIR_OUT;
                        end
                        OPC_READ_SECTOR: begin
                           p_status = ST_RD_BUSY;
                           request_drive(r, OP_READ_SECTOR, p_track, p_sector);
                           p_index_count = 3'd0;
                           p_rnf_watch   = 1'b1;
                        end
                        OPC_WRITE_SECT: begin
                           p_status = ST_WR_BUSY;
                           request_drive(r, OP_WRITE_SECTOR, p_track, p_sector);
                           r.drq_action  = ACT_RAISE;
                           p_byte_ready  = 1'b0;
                           p_index_count = 3'd0;
                           p_rnf_watch   = 1'b1;
                        end
                        OPC_READ_ADDR: begin
                           p_status = ST_RD_BUSY;
                           request_drive(r, OP_READ_ADDR, p_track, 8'h00);
                           p_index_count = 3'd0;
                           p_rnf_watch   = 1'b1;
                        end
                        OPC_FORCE_INT: begin
                           p_status = ST_MOTOR | trk0;
                           if (t.value[3]) r.irq_action = ACT_RAISE;
                           request_drive(r, OP_STOP_ALL, 8'h00, 8'h00);
                        end
                        OPC_FORMAT: begin
                           p_status = ST_RD_BUSY;
                           request_drive(r, OP_FORMAT, p_track, 8'h00);
                        end
                        default: end_in_error(r, ST_RNF_ERR);  // undefined opcode
                     endcase
                  end
               end
               REG_TRACK:  p_track  = t.value;
               REG_SECTOR: p_sector = t.value;
               default: begin
                  r.drq_action = ACT_CLEAR;
                  p_status[1]  = 1'b0;
                  p_data       = t.value;
                  p_byte_ready = 1'b1;
               end
            endcase
         end
         CMD_REG_READ: begin
            case (t.reg_addr)
               REG_CMD_STATUS: begin
                  r.irq_action = ACT_CLEAR;
                  r.read_data  = fdc_cfg.variant ? {p_not_ready, p_status[6:0]} : p_status;
               end
               REG_TRACK:  r.read_data = p_track;
               REG_SECTOR: r.read_data = p_sector;
               default: begin
                  r.drq_action = ACT_CLEAR;
                  p_status[1]  = 1'b0;
                  r.read_data  = p_data;
               end
            endcase
         end
         CMD_LATCH_A: begin
            // lowest bits first, so the highest cleared select bit wins
            if (!fdc_cfg.drive_bypass) begin
               for (int d = 0; d < SEL_LIMIT; d++)
                  if (!t.value[d]) p_drive = 2'(d);
               p_motor = !t.value[5];
            end
            p_side      = !t.value[4];
            p_not_ready = !(p_motor && t.disc_present && !fdc_cfg.drive_bypass);
            if (!t.value[7] && t.disc_present && fdc_cfg.change_clear_enable)
               r.change_clear = 1'b1;
         end
         CMD_LATCH_B: p_density = fdc_cfg.variant ? t.value[2] : !t.value[1];
         CMD_BYTE: begin
            if (p_status[1]) begin
               // overrun: stop current goes out even when bypassing
               p_status     = ST_OVERRUN;
               r.irq_action = ACT_RAISE;
               r.drive_op   = OP_STOP_CURRENT;
            end else begin
               p_data       = t.value;
               p_status[1]  = 1'b1;
               r.drq_action = ACT_RAISE;
            end
         end
         CMD_GETDATA: begin
            if (p_byte_ready) begin
               if (!t.last_byte) begin
                  r.drq_action = ACT_RAISE;
                  p_status[1]  = 1'b1;
               end
               p_byte_ready = 1'b0;
               r.read_data  = p_data;
               r.data_valid = 1'b1;
            end
         end
         CMD_DONE: begin
            case (p_command[7:4])
               OPC_RESTORE: begin
                  p_head       = 8'h00;
                  p_track      = 8'h00;
                  p_status     = ST_MOTOR | ST_TRK0;
                  r.irq_action = ACT_RAISE;
               end
               OPC_SEEK: begin
                  p_head       = p_data;
                  p_track      = p_data;
                  p_status     = ST_MOTOR | ((p_data == 8'h00) ? ST_TRK0 : 8'h00);
                  r.irq_action = ACT_RAISE;
               end
               OPC_STEP_U, OPC_STEP_IN_U, OPC_STEP_OUT_U: begin
                  p_track      = p_head;
                  p_status     = ST_MOTOR | trk0;
                  r.irq_action = ACT_RAISE;
               end
               OPC_STEP, OPC_STEP_IN, OPC_STEP_OUT: begin
                  p_status     = ST_MOTOR | trk0;
                  r.irq_action = ACT_RAISE;
               end
               OPC_READ_SECTOR, OPC_READ_ADDR: begin
                  p_status     = ST_MOTOR | (p_status & ST_TRK0);
                  r.irq_action = ACT_RAISE;
                  if (p_command[7:4] == OPC_READ_ADDR) p_sector = p_track;
               end
               OPC_WRITE_SECT, OPC_FORMAT: begin
                  p_status     = ST_MOTOR;
                  r.irq_action = ACT_RAISE;
               end
               default: ;  // other opcodes only disarm not-found detection
            endcase
            p_rnf_watch = 1'b0;
         end
         CMD_NOTFOUND: end_in_error(r, ST_RNF_ERR);
         CMD_DATACRC:  end_in_error(r, ST_CRC_ERR);
         CMD_HDRCRC:   end_in_error(r, ST_HDRCRC_ERR);
         CMD_WPROT:    end_in_error(r, ST_WPROT_ERR);
         CMD_INDEX: begin
            // counter saturates, so not-found fires once per arming
            if (p_index_count != INDEX_MAX) p_index_count = p_index_count + 3'd1;
            if (p_index_count == INDEX_RNF && p_rnf_watch) end_in_error(r, ST_RNF_ERR);
         end
         CMD_SPINDOWN: p_status[7] = 1'b0;
         default: ;
      endcase
      r.drive_side    = p_side;
      r.drive_density = p_density;
      r.drive_select  = p_drive;
      r.motor_on      = p_motor;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("ERROR response %0d: %s", rsp_count, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %02h, expected %02h", name, got, want));
   endtask

   task automatic add_event_full(input logic [3:0] cmd, input logic [1:0] ra,
                                 input logic [7:0] v, input logic last,
                                 input logic disc);
      req_type t;
      t.cmd          = cmd;
      t.reg_addr     = ra;
      t.value        = v;
      t.last_byte    = last;
      t.disc_present = disc;
      bus_events.push_back(t);
      if (cmd <= CMD_SPINDOWN) stim_count++;
   endtask

   // Don't-care fields are randomised so that every bit toggles
   task automatic add_event(input logic [3:0] cmd, input logic [1:0] ra,
                            input logic [7:0] v);
      add_event_full(cmd, ra, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_VARIANT:      fdc_cfg.variant             = val;
         CSR_DRIVE_BYPASS: fdc_cfg.drive_bypass        = val;
         default:          fdc_cfg.change_clear_enable = val;
      endcase
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : driver
      req_type nxt;
      req_type seen;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            seen.cmd          = req_cmd;
            seen.reg_addr     = req_reg_addr;
            seen.value        = req_value;
            seen.last_byte    = req_last_byte;
            seen.disc_present = req_disc_present;
            predicted_outcomes.push_back(next_outcome(seen));
         end
         // hold the transaction until it is taken
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bus_events.size() != 0) begin
               nxt = bus_events.pop_front();
               req_cmd          <= nxt.cmd;
               req_reg_addr     <= nxt.reg_addr;
               req_value        <= nxt.value;
               req_last_byte    <= nxt.last_byte;
               req_disc_present <= nxt.disc_present;
               req_valid        <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stall pattern
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 4);
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{read_data: rsp_read_data, data_valid: rsp_data_valid,
                 irq_action: rsp_irq_action, drq_action: rsp_drq_action,
                 drive_op: rsp_drive_op, drive_track: rsp_drive_track,
                 drive_sector: rsp_drive_sector, drive_side: rsp_drive_side,
                 drive_density: rsp_drive_density, drive_select: rsp_drive_select,
                 motor_on: rsp_motor_on, change_clear: rsp_change_clear};
         if (predicted_outcomes.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = predicted_outcomes.pop_front();
            check_field("read_data",     got.read_data,         want.read_data);
            check_field("data_valid",    8'(got.data_valid),    8'(want.data_valid));
            check_field("irq_action",    8'(got.irq_action),    8'(want.irq_action));
            check_field("drq_action",    8'(got.drq_action),    8'(want.drq_action));
            check_field("drive_op",      8'(got.drive_op),      8'(want.drive_op));
            check_field("drive_track",   got.drive_track,       want.drive_track);
            check_field("drive_sector",  got.drive_sector,      want.drive_sector);
            check_field("drive_side",    8'(got.drive_side),    8'(want.drive_side));
            check_field("drive_density", 8'(got.drive_density), 8'(want.drive_density));
            check_field("drive_select",  8'(got.drive_select),  8'(want.drive_select));
            check_field("motor_on",      8'(got.motor_on),      8'(want.motor_on));
            check_field("change_clear",  8'(got.change_clear),  8'(want.change_clear));
         end
         rsp_count++;
      end
      case (stall_mode)
         0, 1:    rsp_ready <= 1'b1;
         2:       rsp_ready <= 1'($urandom_range(0, 1));
         3:       rsp_ready <= (stall_tick % 4 != 3);
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Reset, settings phases and stimulus
   initial begin : sequencer
      logic [2:0] setting;
      logic [3:0] lo;
      int         target;
      int         n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         setting = PHASE_SETTINGS[ph*3 +: 3];
         write_csr(CSR_VARIANT,      setting[2]);
         write_csr(CSR_DRIVE_BYPASS, setting[1]);
         write_csr(CSR_CHANGE_CLEAR, setting[0]);

         if (ph == 0) begin
            // directed: extremes, an opcode of each kind and every event, corner cases
            add_event(CMD_REG_READ, REG_CMD_STATUS, 8'h00);
            add_event_full(CMD_LATCH_A, REG_TRACK, 8'h00, 1'b0, 1'b1);
            add_event(CMD_LATCH_B, REG_SECTOR, 8'hFF);
            add_event(CMD_REG_WRITE, REG_DATA, 8'hFF);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h20);   // step, no direction
            add_event(CMD_DONE, REG_DATA, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h1F);   // seek to 255
            add_event(CMD_DONE, REG_CMD_STATUS, 8'hFF);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h4C);   // step in, saturates
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h60);   // ignored while busy
            add_event(CMD_DONE, REG_TRACK, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h0F);   // restore
            add_event(CMD_DONE, REG_SECTOR, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h70);   // step out, clamps at 0
            add_event(CMD_DONE, REG_DATA, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'hA0);   // write sector
            add_event_full(CMD_GETDATA, REG_DATA, 8'h00, 1'b0, 1'b0);  // nothing written
            add_event(CMD_REG_WRITE, REG_DATA, 8'h00);
            add_event_full(CMD_GETDATA, REG_TRACK, 8'hFF, 1'b1, 1'b1);
            add_event(CMD_DONE, REG_CMD_STATUS, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h80);   // read sector
            add_event(CMD_BYTE, REG_CMD_STATUS, 8'h5A);
            add_event(CMD_BYTE, REG_DATA, 8'hA5);              // overrun
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'hC4);   // read address
            repeat (6) add_event(CMD_INDEX, REG_TRACK, 8'h00); // not-found on the fifth
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'hD8);   // force interrupt
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'h90);   // undefined opcode
            add_event(CMD_DONE, REG_CMD_STATUS, 8'h00);
            add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'hFF);   // format
            add_event(CMD_WPROT, REG_CMD_STATUS, 8'h00);
            add_event(CMD_DATACRC, REG_TRACK, 8'h00);
            add_event(CMD_HDRCRC, REG_SECTOR, 8'h00);
            add_event(CMD_NOTFOUND, REG_DATA, 8'h00);
            add_event(CMD_SPINDOWN, REG_CMD_STATUS, 8'h00);
            add_event(4'hF, REG_DATA, 8'hFF);                  // unused transaction kind
            add_event(CMD_REG_READ, REG_CMD_STATUS, 8'h00);
            add_event_full(CMD_LATCH_A, REG_DATA, 8'hFF, 1'b1, 1'b0);
         end

         // random part: mostly well-formed command sequences
         target = stim_count + ITEMS_PER_PHASE;
         while (stim_count < target) begin
            lo = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
               0, 1: begin
                  // type I command and its completion
                  if ($urandom_range(0, 1)) add_event(CMD_REG_WRITE, REG_DATA, pick_byte());
                  if ($urandom_range(0, 2) == 0)
                     add_event(CMD_REG_WRITE, REG_TRACK, pick_byte());
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'($urandom_range(0, 127)));
                  if ($urandom_range(0, 1)) add_event(CMD_REG_READ, REG_CMD_STATUS, 8'h00);
                  add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 1)) add_event(CMD_REG_READ, REG_TRACK, 8'h00);
               end
               2: begin
                  // read sector, bytes mostly collected in time
                  add_event(CMD_REG_WRITE, REG_TRACK, pick_byte());
                  add_event(CMD_REG_WRITE, REG_SECTOR, pick_byte());
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, {OPC_READ_SECTOR, lo});
                  n = $urandom_range(1, 6);
                  repeat (n) begin
                     add_event(CMD_BYTE, 2'($urandom_range(0, 3)), pick_byte());
                     if ($urandom_range(0, 4) != 0) add_event(CMD_REG_READ, REG_DATA, 8'h00);
                  end
                  case ($urandom_range(0, 5))
                     3:       add_event(CMD_DATACRC, 2'($urandom_range(0, 3)), 8'h00);
                     4:       add_event(CMD_HDRCRC, 2'($urandom_range(0, 3)), 8'h00);
                     5:       add_event(CMD_NOTFOUND, 2'($urandom_range(0, 3)), 8'h00);
                     default: add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'h00);
                  endcase
                  add_event(CMD_REG_READ, REG_CMD_STATUS, 8'h00);
               end
               3: begin
                  // write sector, bytes handed to the drive
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, {OPC_WRITE_SECT, lo});
                  if ($urandom_range(0, 3) == 0)
                     add_event(CMD_GETDATA, 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)));
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) begin
                     if ($urandom_range(0, 5) != 0)
                        add_event(CMD_REG_WRITE, REG_DATA, pick_byte());
                     add_event_full(CMD_GETDATA, 2'($urandom_range(0, 3)),
                                    8'($urandom_range(0, 255)), i == n - 1,
                                    1'($urandom_range(0, 1)));
                  end
                  if ($urandom_range(0, 4) == 0)
                     add_event(CMD_WPROT, 2'($urandom_range(0, 3)), 8'h00);
                  else add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'h00);
               end
               4: begin
                  // read address, index pulses towards not-found
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, {OPC_READ_ADDR, lo});
                  n = $urandom_range(0, 8);
                  repeat (n) add_event(CMD_INDEX, 2'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 3) != 0)
                     add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'h00);
                  add_event(CMD_REG_READ, REG_SECTOR, 8'h00);
               end
               5: begin
                  add_event(CMD_REG_WRITE, REG_TRACK, pick_byte());
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, {OPC_FORMAT, lo});
                  if ($urandom_range(0, 2) == 0)
                     add_event(CMD_WPROT, 2'($urandom_range(0, 3)), 8'h00);
                  else add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'h00);
               end
               6: begin
                  // any opcode, force interrupt and undefined ones included
                  add_event(CMD_REG_WRITE, REG_CMD_STATUS, 8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 1))
                     add_event(CMD_DONE, 2'($urandom_range(0, 3)), 8'h00);
                  if ($urandom_range(0, 2) == 0)
                     add_event(CMD_REG_WRITE, REG_CMD_STATUS, {OPC_FORCE_INT, lo});
               end
               7: begin
                  add_event(CMD_LATCH_A, 2'($urandom_range(0, 3)), pick_byte());
                  if ($urandom_range(0, 1))
                     add_event(CMD_LATCH_B, 2'($urandom_range(0, 3)), pick_byte());
                  add_event(CMD_REG_READ, REG_CMD_STATUS, 8'h00);
               end
               8: begin
                  n = $urandom_range(1, 3);
                  repeat (n) add_event(CMD_REG_READ, 2'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 1))
                     add_event(CMD_SPINDOWN, 2'($urandom_range(0, 3)), 8'h00);
               end
               default: begin
                  // noise: anything the fields allow
                  n = $urandom_range(1, 5);
                  repeat (n) add_event(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                                       8'($urandom_range(0, 255)));
               end
            endcase
         end

         // settings change only once the block has gone idle
         do @(negedge clock);
         while (bus_events.size() != 0 || req_valid || predicted_outcomes.size() != 0);
      end

      // allow for anything still in the pipeline
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && predicted_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
src/fdc_regs_pkg.sv
src/fdc_regs_exec.sv
src/floppy_controller_registers_top.sv
bench/tb_top.sv
